[rtl/core/rau_pkg.sv]
// Package for the rational arithmetic unit: types, codes and constants.
package rau_pkg;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int MAG_W = 64;
   localparam int CNT_W = 7;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_CMP = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type_t_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic               is_equal;
      logic [1:0]         status;
   } rsp_type;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NONE    = 4'd0,
      CMD_LOAD    = 4'd1,
      CMD_MUL1    = 4'd2,
      CMD_MUL2    = 4'd3,
      CMD_COMBINE = 4'd4,
      CMD_GCD_SET = 4'd5,
      CMD_GCD_DIV = 4'd6,
      CMD_DIVN    = 4'd7,
      CMD_DIVD    = 4'd8,
      CMD_FINISH  = 4'd9,
      CMD_SWAP    = 4'd10
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type code;
   } cmd_type;

   typedef struct packed {
      logic bad_input;
      logic is_cmp;
      logic gcd_done;
      logic div_done;
      logic second_pass;
   } stat_type;
endpackage

[rtl/core/rational_arith_unit.sv]
// Rational arithmetic unit: add, subtract, multiply, divide and compare
// of signed fractions, result reduced by Euclid's GCD. One transfer is
// worked at a time, while the previous result may still wait in the output
// register. A transfer with a zero denominator or divisor skips the
// reduction; any other runs Euclid's steps (compare: over both operands)
// and both final divisions on the 64-bit bit-serial divider.
module rational_arith_unit
   import rau_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type_t_type req_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data
);
   cmd_type  cmd;
   stat_type stat;

   rau_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .stat(stat), .cmd(cmd)
   );

   rau_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .cmd(cmd),
      .stat(stat), .rsp_data(rsp_data)
   );
endmodule

[rtl/core/rau_divider.sv]
// Restoring 64-bit divider, one quotient bit per cycle.
module rau_divider
   import rau_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] dividend,
   input  logic [MAG_W-1:0] divisor,
   output logic             done,
   output logic [MAG_W-1:0] quotient,
   output logic [MAG_W-1:0] remainder
);
   logic [MAG_W-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [MAG_W:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff, q_ff[MAG_W-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[MAG_W]) begin
            r_in = trial[MAG_W-1:0];
            q_in = {q_ff[MAG_W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[MAG_W-2:0], q_ff[MAG_W-1]};
            q_in = {q_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule

[rtl/core/rau_datapath.sv]
// Datapath: operand registers, multiplier, adder and divider for reduction.
module rau_datapath
   import rau_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  req_type_t_type req_data,
   input  cmd_type        cmd,
   output stat_type       stat,
   output rsp_type        rsp_data
);
   logic [2:0]       op_ff;
   logic             an_s_ff, bn_s_ff;
   logic [MAG_W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [MAG_W-1:0] p_ff, q_ff, rd_ff;
   logic             ps_ff, qs_ff, rs_ff;
   logic [MAG_W-1:0] x_ff, y_ff, num_ff, den_ff;
   logic             bad_ff, pass_ff;
   logic             okA_ff, sA_ff;
   logic [MAG_W-1:0] nA_ff, dA_ff;
   logic             dq_den_ff;
   rsp_type          out_ff;
   rsp_type          fin_rsp;

   logic             div_start;
   logic [MAG_W-1:0] div_a, div_b, div_q, div_r;
   logic             div_done;
   logic [MAG_W-1:0] lim;
   logic             fits;
   logic [MAG_W-1:0] sum_mag;
   logic             sum_s;
   logic [MAG_W-1:0] m_a, m_b;

   function automatic logic [MAG_W-1:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? {32'd0, (~v + 32'd1)} : {32'd0, v};
   endfunction

   assign lim = MAG_W'(1) << (DATA_WIDTH - 1);

   rau_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_a),
      .divisor(div_b), .done(div_done), .quotient(div_q), .remainder(div_r)
   );

   always_comb begin
      div_start = 1'b0;
      div_a = x_ff;
      div_b = y_ff;
      case (cmd.code)
         CMD_GCD_SET: div_start = (y_ff != '0);
         CMD_GCD_DIV: div_start = 1'b1;
         CMD_DIVN: begin
            div_start = 1'b1;
            div_a = num_ff;
            div_b = x_ff;
         end
         CMD_DIVD: begin
            div_start = 1'b1;
            div_a = den_ff;
            div_b = x_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      m_a = an_ff;
      m_b = bd_ff;
      case (op_ff)
         OP_MUL: m_b = bn_ff;
         default: ;
      endcase
   end

   always_comb begin
      if (ps_ff == qs_ff) begin
         sum_s = ps_ff;
         sum_mag = p_ff + q_ff;
      end else if (p_ff >= q_ff) begin
         sum_s = ps_ff;
         sum_mag = p_ff - q_ff;
      end else begin
         sum_s = qs_ff;
         sum_mag = q_ff - p_ff;
      end
   end

   assign fits = (den_ff <= lim - 1'b1) &&
                 (rs_ff ? (num_ff <= lim) : (num_ff <= lim - 1'b1));

   always_comb begin
      fin_rsp = '0;
      if (bad_ff) begin
         fin_rsp.status = ST_ZERO_DEN;
      end else if (op_ff[2]) begin
         fin_rsp.is_equal = (sA_ff == (rs_ff && num_ff != '0)) &&
                            nA_ff == num_ff && dA_ff == den_ff;
         if (okA_ff) begin
            fin_rsp.res_num = sA_ff ? 32'(-nA_ff) : nA_ff[31:0];
            fin_rsp.res_den = dA_ff[30:0];
         end else begin
            fin_rsp.status = ST_OVERFLOW;
         end
      end else if (fits) begin
         fin_rsp.res_num = (rs_ff && num_ff != '0) ? 32'(-num_ff) : num_ff[31:0];
         fin_rsp.res_den = den_ff[30:0];
      end else begin
         fin_rsp.status = ST_OVERFLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= 1'b0;
         bad_ff  <= 1'b0;
      end else begin
         case (cmd.code)
            CMD_LOAD: begin
               pass_ff <= 1'b0;
               bad_ff <= (req_data.a_den == '0) || (req_data.b_den == '0) ||
                         (req_data.req_type == OP_DIV && req_data.b_num == '0);
            end
            CMD_SWAP: pass_ff <= 1'b1;
            default: ;
         endcase
      end
      case (cmd.code)
         CMD_LOAD: begin
            op_ff <= req_data.req_type;
            an_ff <= mag32(req_data.a_num);
            ad_ff <= mag32(req_data.a_den);
            bn_ff <= mag32(req_data.b_num);
            bd_ff <= mag32(req_data.b_den);
            an_s_ff <= (req_data.a_num[31] ^ req_data.a_den[31]) && req_data.a_num != '0;
            bn_s_ff <= (req_data.b_num[31] ^ req_data.b_den[31]) && req_data.b_num != '0;
         end
         CMD_MUL1: begin
            p_ff <= m_a[31:0] * m_b[31:0];
            ps_ff <= an_s_ff;
            if (op_ff[2]) begin
               num_ff <= an_ff;
               den_ff <= ad_ff;
               rs_ff <= an_s_ff;
               x_ff <= an_ff;
               y_ff <= ad_ff;
            end
         end
         CMD_MUL2: begin
            case (op_ff)
               OP_DIV: begin
                  q_ff <= ad_ff[31:0] * bn_ff[31:0];
                  ps_ff <= an_s_ff ^ bn_s_ff;
               end
               OP_MUL: begin
                  q_ff <= ad_ff[31:0] * bd_ff[31:0];
                  ps_ff <= an_s_ff ^ bn_s_ff;
               end
               default: begin
                  q_ff <= bn_ff[31:0] * ad_ff[31:0];
                  qs_ff <= (op_ff == OP_SUB) ? (!bn_s_ff && bn_ff != '0) : bn_s_ff;
               end
            endcase
            rd_ff <= ad_ff[31:0] * bd_ff[31:0];
         end
         CMD_COMBINE: begin
            case (op_ff)
               OP_ADD, OP_SUB: begin
                  num_ff <= sum_mag;
                  rs_ff <= sum_s && sum_mag != '0;
                  den_ff <= rd_ff;
                  x_ff <= sum_mag;
                  y_ff <= rd_ff;
               end
               default: begin
                  num_ff <= p_ff;
                  rs_ff <= ps_ff && p_ff != '0;
                  den_ff <= q_ff;
                  x_ff <= p_ff;
                  y_ff <= q_ff;
               end
            endcase
         end
         CMD_GCD_SET: if (y_ff == '0 && x_ff == '0) x_ff <= MAG_W'(1);
         CMD_GCD_DIV: begin
            x_ff <= y_ff;
            y_ff <= div_r;
         end
         CMD_SWAP: begin
            okA_ff <= fits;
            sA_ff <= rs_ff && num_ff != '0;
            nA_ff <= num_ff;
            dA_ff <= den_ff;
            num_ff <= bn_ff;
            den_ff <= bd_ff;
            rs_ff <= bn_s_ff;
            x_ff <= bn_ff;
            y_ff <= bd_ff;
         end
         CMD_FINISH: out_ff <= fin_rsp;
         default: if (div_done) begin
            if (dq_den_ff) den_ff <= div_q;
            else num_ff <= div_q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) dq_den_ff <= 1'b0;
      else if (cmd.code == CMD_DIVN) dq_den_ff <= 1'b0;
      else if (cmd.code == CMD_DIVD) dq_den_ff <= 1'b1;
   end

   assign stat.bad_input = bad_ff;
   assign stat.is_cmp = op_ff[2];
   assign stat.gcd_done = (y_ff == '0);
   assign stat.div_done = div_done;
   assign stat.second_pass = pass_ff;
   assign rsp_data = out_ff;
endmodule

[rtl/core/rau_controller.sv]
// Controller: sequences multiply, Euclid reduction and output handshake.
module rau_controller
   import rau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);
   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_MUL1  = 12'b000000000010,
      S_MUL2  = 12'b000000000100,
      S_COMB  = 12'b000000001000,
      S_GSET  = 12'b000000010000,
      S_GWAIT = 12'b000000100000,
      S_DN    = 12'b000001000000,
      S_DNW   = 12'b000010000000,
      S_DD    = 12'b000100000000,
      S_DDW   = 12'b001000000000,
      S_FIN   = 12'b010000000000,
      S_SWP   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      vld_ff, vld_in;

   always_comb begin
      state_in = state_ff;
      cmd.code = CMD_NONE;
      vld_in = vld_ff && rsp_stall;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.code = CMD_LOAD;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.code = CMD_MUL1;
            state_in = stat.bad_input ? S_FIN : (stat.is_cmp ? S_GSET : S_MUL2);
         end
         S_MUL2: begin
            cmd.code = CMD_MUL2;
            state_in = S_COMB;
         end
         S_COMB: begin
            cmd.code = CMD_COMBINE;
            state_in = S_GSET;
         end
         S_GSET: begin
            cmd.code = CMD_GCD_SET;
            state_in = stat.gcd_done ? S_DN : S_GWAIT;
         end
         S_GWAIT: if (stat.div_done) begin
            cmd.code = CMD_GCD_DIV;
            state_in = S_GSET;
         end
         S_DN: begin
            cmd.code = CMD_DIVN;
            state_in = S_DNW;
         end
         S_DNW: if (stat.div_done) state_in = S_DD;
         S_DD: begin
            cmd.code = CMD_DIVD;
            state_in = S_DDW;
         end
         S_DDW: if (stat.div_done) begin
            state_in = (stat.is_cmp && !stat.second_pass) ? S_SWP : S_FIN;
         end
         S_SWP: begin
            cmd.code = CMD_SWAP;
            state_in = S_GSET;
         end
         S_FIN: if (!vld_ff || !rsp_stall) begin
            cmd.code = CMD_FINISH;
            vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = vld_ff;
endmodule

[sim/rational_arith_unit_tb.sv]
// Self-checking testbench for the rational arithmetic unit: random and directed fractions.
`timescale 1ns / 1ps

module rational_arith_unit_tb;
   import rau_pkg::*;

   localparam int N_RANDOM    = 1200;
   localparam int WATCHDOG    = 200000;
   localparam int HOLD_CYCLES = 3000;
   localparam int TAIL_CYCLES = 20000;

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_stall;
   req_type_t_type req_data;
   logic           rsp_valid;
   logic           rsp_stall;
   rsp_type        rsp_data;

   req_type_t_type pending_reqs[$];
   rsp_type        expected_rsps[$];
   int             mismatches;
   int             n_sent;
   int             n_checked;
   int             idle_cycles;
   int             burst_left;
   int             gap_left;
   int             hold_left;
   int             hold_done;
   int             op_count[8];

   rational_arith_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // Brings |num|/den to lowest terms, returns 1 when it fits the result fields.
   function automatic bit lowest_terms(inout logic [63:0] mag, inout logic neg,
                                       inout logic [63:0] den);
      logic [63:0] g;
      logic [63:0] lim;
      lim = 64'd1 << 31;
      g = gcd64(mag, den);
      if (g == 0) g = 1;
      mag = mag / g;
      den = den / g;
      if (mag == 0) neg = 1'b0;
      if (den > lim - 1) return 1'b0;
      if (neg ? (mag > lim) : (mag > lim - 1)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic rsp_type fraction_result(req_type_t_type r);
      rsp_type     o;
      logic [2:0]  op;
      logic        an_s, ad_s, bn_s, bd_s, rn_s, bnr_s, ps, qs;
      logic [63:0] an, ad, bn, bd, rn, rd, bnr, bdr, pm, qm;
      bit          fits;
      o = '0;
      op = r.req_type;
      an_s = r.a_num[31]; an = r.a_num[31] ? 64'(-r.a_num) & 64'hFFFF_FFFF : 64'(r.a_num);
      ad_s = r.a_den[31]; ad = r.a_den[31] ? 64'(-r.a_den) & 64'hFFFF_FFFF : 64'(r.a_den);
      bn_s = r.b_num[31]; bn = r.b_num[31] ? 64'(-r.b_num) & 64'hFFFF_FFFF : 64'(r.b_num);
      bd_s = r.b_den[31]; bd = r.b_den[31] ? 64'(-r.b_den) & 64'hFFFF_FFFF : 64'(r.b_den);
      if (ad == 0 || bd == 0 || (op == OP_DIV && bn == 0)) begin
         o.status = ST_ZERO_DEN;
         return o;
      end
      an_s = (an_s != ad_s) && an != 0;
      bn_s = (bn_s != bd_s) && bn != 0;
      if (op[2]) begin
         rn = an; rn_s = an_s; rd = ad;
         bnr = bn; bnr_s = bn_s; bdr = bd;
         fits = lowest_terms(rn, rn_s, rd);
         void'(lowest_terms(bnr, bnr_s, bdr));
         o.is_equal = (rn_s == bnr_s) && (rn == bnr) && (rd == bdr);
      end else begin
         if (op == OP_ADD || op == OP_SUB) begin
            ps = an_s; pm = an * bd;
            qs = (op == OP_SUB) ? (!bn_s && bn != 0) : bn_s;
            qm = bn * ad;
            if (ps == qs) begin
               rn_s = ps; rn = pm + qm;
            end else if (pm >= qm) begin
               rn_s = ps; rn = pm - qm;
            end else begin
               rn_s = qs; rn = qm - pm;
            end
            if (rn == 0) rn_s = 1'b0;
            rd = ad * bd;
         end else if (op == OP_MUL) begin
            rn = an * bn;
            rn_s = (an_s != bn_s) && rn != 0;
            rd = ad * bd;
         end else begin
            rn = an * bd;
            rn_s = (an_s != bn_s) && rn != 0;
            rd = ad * bn;
         end
         fits = lowest_terms(rn, rn_s, rd);
      end
      if (fits) begin
         o.res_num = rn_s ? -32'(rn) : 32'(rn);
         o.res_den = rd[30:0];
      end else begin
         o.status = ST_OVERFLOW;
      end
      return o;
   endfunction

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'd0;
         3, 4: return 32'($urandom_range(0, 24)) - 32'd12;
         5, 6: return 32'($urandom_range(0, 2000)) - 32'd1000;
         7: return 32'($urandom_range(0, 200000)) - 32'd100000;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_req(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
      req_type_t_type r;
      r.req_type = op;
      r.a_num = an;
      r.a_den = ad;
      r.b_num = bn;
      r.b_den = bd;
      pending_reqs.push_back(r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(fraction_result(req_data));
            op_count[req_data.req_type]++;
            n_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pending_reqs.pop_front();
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 0;
      end else begin
         if (hold_done == 0 && n_sent == 40) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            case ((n_sent / 100) % 3)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 1) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            n_checked++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected result transfer %p", rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.res_num !== want.res_num || rsp_data.res_den !== want.res_den
                   || rsp_data.is_equal !== want.is_equal
                   || rsp_data.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"ERROR: result %0d: expected %0d/%0d eq=%0b st=%0d, ",
                               "got %0d/%0d eq=%0b st=%0d"},
                              n_checked, want.res_num, want.res_den, want.is_equal,
                              want.status, rsp_data.res_num, rsp_data.res_den,
                              rsp_data.is_equal, rsp_data.status);
               end
            end
         end
         if (idle_cycles >= WATCHDOG) begin
            $display("ERROR: no transfer for %0d cycles", WATCHDOG);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      logic [2:0] op;
      int         scale;
      mismatches = 0;
      n_sent = 0;
      n_checked = 0;
      idle_cycles = 0;
      foreach (op_count[i]) op_count[i] = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;

      queue_req(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
      queue_req(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
      queue_req(OP_MUL, -32'd6, 32'd4, 32'd2, -32'd3);
      queue_req(OP_DIV, 32'd3, 32'd4, -32'd9, 32'd8);
      queue_req(OP_CMP, -32'd4, -32'd8, 32'd1, 32'd2);
      queue_req(OP_CMP, 32'd4, 32'd8, -32'd1, 32'd2);
      queue_req(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
      queue_req(OP_CMP, 32'd1, 32'd1, 32'd1, 32'd0);
      queue_req(OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
      queue_req(OP_MUL, 32'd0, -32'd7, 32'd5, 32'd3);
      queue_req(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
      queue_req(OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
      queue_req(OP_MUL, 32'h8000_0000, 32'd1, 32'd1, -32'd1);
      queue_req(OP_CMP, 32'd1, 32'h8000_0000, 32'd1, 32'h8000_0000);
      queue_req(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_req(OP_MUL, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF);
      queue_req(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(3'd5, 32'd2, 32'd4, 32'd1, 32'd2);
      queue_req(3'd6, 32'd3, 32'd1, 32'd2, 32'd1);
      queue_req(3'd7, 32'd0, 32'd9, 32'd0, -32'd3);
      queue_req(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);

      for (int i = 0; i < N_RANDOM; i++) begin
         op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
         if ($urandom_range(0, 1) == 0) begin
            scale = $urandom_range(1, 50);
            queue_req(op, 32'($urandom_range(0, 200)) - 32'd100, 32'($urandom_range(1, 60)),
                      32'($urandom_range(0, 200)) - 32'd100,
                      32'($urandom_range(1, 60)) * scale);
         end else begin
            queue_req(op, rand_field(), rand_field(), rand_field(), rand_field());
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d fractions: add %0d, sub %0d, mul %0d, div %0d, compare %0d,",
               n_sent, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL],
               op_count[OP_DIV], op_count[4] + op_count[5] + op_count[6] + op_count[7]);
      $display("with zero denominators, overflow, spare codes and a long result hold-off.");
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatches, expected_rsps.size());
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

[sim.f]
rtl/core/rau_pkg.sv
rtl/core/rau_divider.sv
rtl/core/rau_datapath.sv
rtl/core/rau_controller.sv
rtl/core/rational_arith_unit.sv
sim/rational_arith_unit_tb.sv
